/* rtl/crs_pkg.sv */
// Shared constants, command/status types and opcodes for the Catmull-Rom
// segment evaluator. No dependencies; crs_ctrl, crs_dp and the top level use it.
`default_nettype none
package crs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int FRAC_BITS  = 16;

  localparam int COORDW   = 32;
  localparam int NLANES   = 3;
  localparam int PTW      = COORDW * NLANES;
  localparam int NTAPS    = 4;
  localparam int MIN_PTS  = 4;
  localparam int NSTEPS   = 3;

  localparam int IDXW     = 6;
  localparam int TWW      = 6;
  localparam int TFW      = 16;
  localparam int PCW      = 7;

  localparam int AW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW     = ($clog2(MAX_POINTS + 1) > PCW) ? $clog2(MAX_POINTS + 1) : PCW;
  localparam int CMPW     = CNTW + 1;
  localparam int SW       = TWW + 1;

  localparam int UP_SHIFT   = (FRAC_BITS >= TFW) ? FRAC_BITS - TFW : 0;
  localparam int DOWN_SHIFT = (FRAC_BITS >= TFW) ? 0 : TFW - FRAC_BITS;
  localparam int UW         = FRAC_BITS + 1;
  localparam int VW         = COORDW + 6;
  localparam int PW         = VW + UW + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef struct packed {
    logic       wr;
    logic       load;
    logic       shift;
    logic       coef;
    logic       mul;
    logic       add;
    logic       out_load;
    logic [1:0] rd_cnt;
    logic [1:0] step;
  } crs_cmd_t;

  typedef struct packed {
    logic range_err;
  } crs_status_t;

endpackage
`default_nettype wire

/* rtl/crs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module crs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/crs_ctrl.sv */
// Sequencer for point writes and segment evaluation: read taps, form
// coefficients, Horner steps, output beat. Depends on crs_pkg.
`default_nettype none
module crs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                opcode_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  input  wire crs_pkg::crs_status_t status_i,
  output crs_pkg::crs_cmd_t        cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_COEF = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_ADD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.rd_cnt = cnt_q;
    cmd_o.step   = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == crs_pkg::OP_WRITE) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            cnt_d      = '0;
            state_d    = status_i.range_err ? ST_DONE : ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.shift = (cnt_q != 2'd0);
        if (cnt_q == 2'(crs_pkg::NTAPS - 1)) begin
          state_d = ST_LAST;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      ST_LAST: begin
        cmd_o.shift = 1'b1;
        state_d     = ST_COEF;
      end
      ST_COEF: begin
        cmd_o.coef = 1'b1;
        step_d     = '0;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        if (step_q == 2'(crs_pkg::NSTEPS - 1)) begin
          state_d = ST_DONE;
        end else begin
          step_d  = step_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/crs_dp.sv */
// Datapath: point store, tap registers, coefficient and Horner lanes for
// x, y and z, saturation and output registers. Depends on crs_pkg, crs_ram.
`default_nettype none
module crs_dp (
  input  wire logic                                   clk_i,
  input  wire crs_pkg::crs_cmd_t                      cmd_i,
  output crs_pkg::crs_status_t                        status_o,
  input  wire logic [crs_pkg::PCW-1:0]                point_count_i,
  input  wire logic [crs_pkg::IDXW-1:0]               point_index_i,
  input  wire logic signed [crs_pkg::COORDW-1:0]      coord_x_i,
  input  wire logic signed [crs_pkg::COORDW-1:0]      coord_y_i,
  input  wire logic signed [crs_pkg::COORDW-1:0]      coord_z_i,
  input  wire logic [crs_pkg::TWW-1:0]                t_whole_i,
  input  wire logic [crs_pkg::TFW-1:0]                t_frac_i,
  output logic signed [crs_pkg::COORDW-1:0]           pos_x_o,
  output logic signed [crs_pkg::COORDW-1:0]           pos_y_o,
  output logic signed [crs_pkg::COORDW-1:0]           pos_z_o,
  output logic                                        range_error_o
);

  localparam int VW = crs_pkg::VW;
  localparam int PW = crs_pkg::PW;
  localparam int UW = crs_pkg::UW;
  localparam int NL = crs_pkg::NLANES;
  localparam int CW = crs_pkg::COORDW;
  localparam int SW = crs_pkg::SW;

  localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (crs_pkg::FRAC_BITS - 1);
  localparam logic signed [VW-1:0] SAT_HI   = {{(VW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_LO   = {{(VW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

  // evaluate setup
  logic [crs_pkg::CNTW-1:0]        pc_ext, count;
  logic [SW-1:0]                   s_d;
  logic [UW-1:0]                   u_d;
  logic [crs_pkg::FRAC_BITS+16:0]  u_wide;
  logic                            err_d;

  logic [SW-1:0] s_q;
  logic [UW-1:0] u_q;
  logic          err_q;

  always_comb begin
    pc_ext = crs_pkg::CNTW'(point_count_i);
    count  = (pc_ext > crs_pkg::CNTW'(crs_pkg::MAX_POINTS)) ?
             crs_pkg::CNTW'(crs_pkg::MAX_POINTS) : pc_ext;
    u_wide = ((crs_pkg::FRAC_BITS + 17)'(t_frac_i) << crs_pkg::UP_SHIFT) >>
             crs_pkg::DOWN_SHIFT;
    if ((t_frac_i == '0) && (t_whole_i != '0)) begin
      s_d = SW'(t_whole_i);
      u_d = UW'(1) << crs_pkg::FRAC_BITS;
    end else begin
      s_d = SW'(t_whole_i) + SW'(1);
      u_d = u_wide[UW-1:0];
    end
    err_d = (count < crs_pkg::CNTW'(crs_pkg::MIN_PTS)) ||
            ((crs_pkg::CMPW'(s_d) + crs_pkg::CMPW'(2)) >= crs_pkg::CMPW'(count));
  end

  assign status_o.range_err = err_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q   <= s_d;
      u_q   <= u_d;
      err_q <= err_d;
    end
  end

  // point store
  logic                          ram_we;
  logic [crs_pkg::AW-1:0]        ram_waddr, ram_raddr;
  logic [crs_pkg::PTW-1:0]       ram_wdata, ram_rdata;
  logic [SW:0]                   rd_sum;

  assign ram_we    = cmd_i.wr && (32'(point_index_i) < crs_pkg::MAX_POINTS);
  assign ram_waddr = crs_pkg::AW'(point_index_i);
  assign ram_wdata = {coord_z_i, coord_y_i, coord_x_i};
  assign rd_sum    = (SW + 1)'(s_q) + (SW + 1)'(cmd_i.rd_cnt) - (SW + 1)'(1);
  assign ram_raddr = crs_pkg::AW'(rd_sum);

  crs_ram #(
    .WIDTH(crs_pkg::PTW),
    .DEPTH(crs_pkg::MAX_POINTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // lanes
  logic signed [CW-1:0] p0_q [NL];
  logic signed [CW-1:0] p1_q [NL];
  logic signed [CW-1:0] p2_q [NL];
  logic signed [CW-1:0] p3_q [NL];
  logic signed [VW-1:0] a2_q [NL];
  logic signed [VW-1:0] a1_q [NL];
  logic signed [VW-1:0] a0_q [NL];
  logic signed [VW-1:0] v_q  [NL];
  logic signed [PW-1:0] prod_q [NL];
  logic signed [CW-1:0] pos_q [NL];
  logic                 range_error_q;

  logic signed [VW-1:0] a3_c [NL];
  logic signed [VW-1:0] a2_c [NL];
  logic signed [VW-1:0] a1_c [NL];
  logic signed [VW-1:0] a0_c [NL];
  logic signed [VW-1:0] nxt_c [NL];
  logic signed [PW-1:0] rnd_c [NL];
  logic signed [VW-1:0] half_c [NL];
  logic signed [CW-1:0] sat_c [NL];
  logic signed [UW:0]   u_s;

  assign u_s = {1'b0, u_q};

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      a3_c[l] = -VW'(p0_q[l]) + (VW'(p1_q[l]) <<< 1) + VW'(p1_q[l])
                - (VW'(p2_q[l]) <<< 1) - VW'(p2_q[l]) + VW'(p3_q[l]);
      a2_c[l] = (VW'(p0_q[l]) <<< 1) - (VW'(p1_q[l]) <<< 2) - VW'(p1_q[l])
                + (VW'(p2_q[l]) <<< 2) - VW'(p3_q[l]);
      a1_c[l] = VW'(p2_q[l]) - VW'(p0_q[l]);
      a0_c[l] = VW'(p1_q[l]) <<< 1;
      unique case (cmd_i.step)
        2'd0:    nxt_c[l] = a2_q[l];
        2'd1:    nxt_c[l] = a1_q[l];
        default: nxt_c[l] = a0_q[l];
      endcase
      rnd_c[l]  = prod_q[l] + RND_HALF;
      half_c[l] = (v_q[l] + VW'(1)) >>> 1;
      if (half_c[l] > SAT_HI) begin
        sat_c[l] = SAT_HI[CW-1:0];
      end else if (half_c[l] < SAT_LO) begin
        sat_c[l] = SAT_LO[CW-1:0];
      end else begin
        sat_c[l] = half_c[l][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NL; l++) begin
      if (cmd_i.shift) begin
        p0_q[l] <= p1_q[l];
        p1_q[l] <= p2_q[l];
        p2_q[l] <= p3_q[l];
        p3_q[l] <= ram_rdata[l*CW +: CW];
      end
      if (cmd_i.coef) begin
        a2_q[l] <= a2_c[l];
        a1_q[l] <= a1_c[l];
        a0_q[l] <= a0_c[l];
        v_q[l]  <= a3_c[l];
      end
      if (cmd_i.mul) begin
        prod_q[l] <= v_q[l] * u_s;
      end
      if (cmd_i.add) begin
        v_q[l] <= VW'(rnd_c[l] >>> crs_pkg::FRAC_BITS) + nxt_c[l];
      end
      if (cmd_i.out_load) begin
        pos_q[l] <= err_q ? '0 : sat_c[l];
      end
    end
    if (cmd_i.out_load) begin
      range_error_q <= err_q;
    end
  end

  assign pos_x_o       = pos_q[0];
  assign pos_y_o       = pos_q[1];
  assign pos_z_o       = pos_q[2];
  assign range_error_o = range_error_q;

endmodule
`default_nettype wire

/* rtl/catmull_rom_segment_eval.sv */
// Top level of the Catmull-Rom segment evaluator: point-count register,
// sequencer and datapath. Depends on crs_pkg, crs_ctrl, crs_dp.
//
// A write beat (opcode 0) stores one 3D control point without leaving
// idle, so the next beat can follow it. An evaluate beat (opcode 1) holds
// off further beats while it runs: four reads of the point store, a state
// for the last read data, one for the blend coefficients, three Horner
// steps (multiply into a product register, then round and add), a state to
// load the result and the return to idle, where the next beat is taken.
// An evaluate beat that is out of range goes from idle straight to the
// result load. The result waits in an output register, so a new beat
// is taken while the last result is still stalled; an evaluation finishing
// while that result is still held waits for it to leave.
`default_nettype none
module catmull_rom_segment_eval (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [crs_pkg::PCW-1:0]             cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                opcode_i,
  input  wire logic [crs_pkg::IDXW-1:0]            point_index_i,
  input  wire logic signed [crs_pkg::COORDW-1:0]   coord_x_i,
  input  wire logic signed [crs_pkg::COORDW-1:0]   coord_y_i,
  input  wire logic signed [crs_pkg::COORDW-1:0]   coord_z_i,
  input  wire logic [crs_pkg::TWW-1:0]             t_whole_i,
  input  wire logic [crs_pkg::TFW-1:0]             t_frac_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [crs_pkg::COORDW-1:0]        pos_x_o,
  output logic signed [crs_pkg::COORDW-1:0]        pos_y_o,
  output logic signed [crs_pkg::COORDW-1:0]        pos_z_o,
  output logic                                     range_error_o
);

  logic [crs_pkg::PCW-1:0] point_count_q;
  crs_pkg::crs_cmd_t       cmd;
  crs_pkg::crs_status_t    status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
    end else if (cfg_we_i) begin
      point_count_q <= cfg_wdata_i;
    end
  end

  crs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  crs_dp u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .point_count_i (point_count_q),
    .point_index_i (point_index_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .t_whole_i     (t_whole_i),
    .t_frac_i      (t_frac_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .range_error_o (range_error_o)
  );

endmodule
`default_nettype wire
